### rtl/core/assert_macros.svh
// Assertion helpers used by the property checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk, skipped while rst_n is low.
`define BHFA_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bhfa check failed");

// Check that a condition never holds on a rising edge of clk.
`define BHFA_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("bhfa forbidden condition seen");

`endif

### rtl/core/bhfa_pkg.sv
package bhfa_pkg;

    // Configuration register indexes and port width
    localparam int CFG_INDEX_W = 4;
    localparam logic [CFG_INDEX_W-1:0] REG_CONDUCTIVITY = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HORIZON      = 4'd1;

    // Reset values of the registers (1.0 in Q16.16)
    localparam logic [31:0] RESET_CONDUCTIVITY = 32'd65536;
    localparam logic [31:0] RESET_HORIZON      = 32'd65536;

    // pi in Q2.30, heat factor, full damage
    localparam logic [31:0] PI_Q30      = 32'd3373259426;
    localparam logic [34:0] HEAT_FACTOR = 35'd6;
    localparam logic [16:0] DAMAGE_ONE  = 17'd65536;
    localparam int          MICRO_SHIFT = 94;

    localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;
    localparam logic [63:0] POS64  = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic signed [31:0] self_x;
        logic signed [31:0] self_y;
        logic signed [31:0] self_z;
        logic signed [31:0] nbr_x;
        logic signed [31:0] nbr_y;
        logic signed [31:0] nbr_z;
        logic signed [31:0] self_temp_change;
        logic signed [31:0] nbr_temp_change;
        logic        [31:0] nbr_volume;
        logic        [16:0] bond_damage;
        logic               last_bond;
    } bond_in_t;

    typedef struct packed {
        logic signed [63:0] heat_flow_sum;
        logic               zero_length_seen;
        logic               saturated;
    } result_t;

    // Classified bond handed from front to back
    typedef struct packed {
        logic [32:0] len;
        logic [32:0] adt;
        logic        neg;
        logic [16:0] weight;
        logic [31:0] volume;
        logic        last;
    } bond_job_t;

endpackage

### rtl/core/bond_heat_flow_accumulator.sv
// Channel   Direction  Handshake                 Word
// bond      in         push / full               bond_in_t, one bond
// result    out        pop / empty               result_t, one per last bond
// cfg       in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// A bond passes the front in three squares and 33 root steps; one of nonzero
// length passes the back in 82 shift-add multiply steps, 114 divide steps
// and one accumulate. The back sets the bond rate, while the front may take
// the next bond before the back is done. After reset and after each write
// to a defined register the scale is recomputed (96 multiply, 129 divide
// steps); cfg_ready is low and no bond enters the back meanwhile. Results
// wait in an output register while the next bonds proceed.
module bond_heat_flow_accumulator
    import bhfa_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  bond_in_t               bond,
    output logic                   empty,
    input  logic                   pop,
    output result_t                result,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]            cfg_data
);

    logic        front_valid, front_ready;
    bond_job_t   front_job;
    logic        back_valid, back_ready;
    bond_job_t   back_job;
    logic [63:0] micro_scale;
    logic        micro_busy;

    bhfa_micro u_micro (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .micro_scale (micro_scale),
        .busy        (micro_busy)
    );

    bhfa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .bond      (bond),
        .job_valid (front_valid),
        .job_ready (front_ready),
        .job       (front_job)
    );

    bhfa_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_job),
        .out_valid (back_valid),
        .out_ready (back_ready),
        .out_data  (back_job)
    );

    bhfa_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (back_valid),
        .job_ready   (back_ready),
        .job         (back_job),
        .micro_scale (micro_scale),
        .micro_busy  (micro_busy),
        .empty       (empty),
        .pop         (pop),
        .result      (result)
    );

endmodule

### rtl/core/bhfa_micro.sv
module bhfa_micro
    import bhfa_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]            cfg_data,
    output logic [63:0]            micro_scale,
    output logic                   busy
);

    typedef enum logic [1:0] {MS_IDLE, MS_MUL, MS_DIV} ms_state_t;

    ms_state_t    state_reg;
    logic [31:0]  k_reg, h_reg;
    logic [127:0] a_reg, p_reg, rem_reg;
    logic [31:0]  b_reg;
    logic [7:0]   cnt_reg;
    logic [1:0]   phase_reg;
    logic [128:0] n_reg;
    logic [63:0]  q_reg, m_reg;
    logic         ovf_reg;

    logic         wr, wr_k, wr_h;
    logic [31:0]  k_next, h_next;
    logic [127:0] p_next;
    logic [128:0] rem2, rem_sub;
    logic         ge;
    logic [127:0] rem_next;
    logic [63:0]  q_next;
    logic         ovf_next;
    logic [34:0]  heat_k;

    // Decode register writes
    assign wr     = cfg_valid && cfg_ready;
    assign wr_k   = wr && (cfg_index == REG_CONDUCTIVITY);
    assign wr_h   = wr && (cfg_index == REG_HORIZON);
    assign k_next = wr_k ? cfg_data : k_reg;
    assign h_next = wr_h ? cfg_data : h_reg;
    assign heat_k = HEAT_FACTOR * {3'b000, k_reg};

    // Shift-add step for pi*h^3
    assign p_next = {p_reg[126:0], 1'b0} + (b_reg[31] ? a_reg : 128'd0);

    // Restoring divide step for 6k*2^94 / (pi*h^3)
    assign rem2     = {rem_reg, n_reg[128]};
    assign ge       = rem2 >= {1'b0, a_reg};
    assign rem_sub  = rem2 - {1'b0, a_reg};
    assign rem_next = ge ? rem_sub[127:0] : rem2[127:0];
    assign q_next   = {q_reg[62:0], ge};
    assign ovf_next = ovf_reg | q_reg[63];

    // Sequence the scale computation after reset and on each write to a defined register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MS_MUL;
            k_reg     <= RESET_CONDUCTIVITY;
            h_reg     <= RESET_HORIZON;
            a_reg     <= {96'd0, PI_Q30};
            p_reg     <= '0;
            b_reg     <= RESET_HORIZON;
            cnt_reg   <= 8'd32;
            phase_reg <= 2'd0;
            n_reg     <= '0;
            rem_reg   <= '0;
            q_reg     <= '0;
            ovf_reg   <= 1'b0;
            m_reg     <= '0;
        end
        else
        begin
            unique case (state_reg)
                MS_IDLE:
                begin
                    k_reg <= k_next;
                    h_reg <= h_next;
                    if (wr_k || wr_h)
                    begin
                        a_reg     <= {96'd0, PI_Q30};
                        p_reg     <= '0;
                        b_reg     <= h_next;
                        cnt_reg   <= 8'd32;
                        phase_reg <= 2'd0;
                        state_reg <= MS_MUL;
                    end
                end
                MS_MUL:
                begin
                    p_reg   <= p_next;
                    b_reg   <= {b_reg[30:0], 1'b0};
                    cnt_reg <= cnt_reg - 8'd1;
                    if (cnt_reg == 8'd1)
                    begin
                        a_reg <= p_next;
                        if (phase_reg == 2'd2)
                        begin
                            n_reg     <= {heat_k, {MICRO_SHIFT{1'b0}}};
                            rem_reg   <= '0;
                            q_reg     <= '0;
                            ovf_reg   <= 1'b0;
                            cnt_reg   <= 8'd129;
                            state_reg <= MS_DIV;
                        end
                        else
                        begin
                            p_reg     <= '0;
                            b_reg     <= h_reg;
                            cnt_reg   <= 8'd32;
                            phase_reg <= phase_reg + 2'd1;
                        end
                    end
                end
                MS_DIV:
                begin
                    if (a_reg == 128'd0)
                    begin
                        m_reg     <= '1;
                        state_reg <= MS_IDLE;
                    end
                    else
                    begin
                        rem_reg <= rem_next;
                        n_reg   <= {n_reg[127:0], 1'b0};
                        q_reg   <= q_next;
                        ovf_reg <= ovf_next;
                        cnt_reg <= cnt_reg - 8'd1;
                        if (cnt_reg == 8'd1)
                        begin
                            m_reg     <= ovf_next ? 64'hFFFF_FFFF_FFFF_FFFF : q_next;
                            state_reg <= MS_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= MS_IDLE;
                end
            endcase
        end
    end

    assign busy        = (state_reg != MS_IDLE);
    assign cfg_ready   = !busy;
    assign micro_scale = m_reg;

endmodule

### rtl/core/bhfa_front.sv
module bhfa_front
    import bhfa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  bond_in_t  bond,
    output logic      job_valid,
    input  logic      job_ready,
    output bond_job_t job
);

    typedef enum logic [1:0] {F_IDLE, F_SQ, F_ROOT, F_PUSH} f_state_t;

    f_state_t    state_reg;
    logic [32:0] mag_reg [3];
    logic [1:0]  sel_reg;
    logic [65:0] sum_reg;
    logic [34:0] rem_reg;
    logic [32:0] root_reg;
    logic [5:0]  cnt_reg;
    logic [32:0] adt_reg;
    logic        neg_reg;
    logic [16:0] weight_reg;
    logic [31:0] volume_reg;
    logic        last_reg;

    logic               accept;
    logic signed [32:0] dx, dy, dz, dt;
    logic [32:0]        mx, my, mz, mt;
    logic [65:0]        sq;
    logic [36:0]        rem2, trial, rem_sub;
    logic               ge;
    logic [16:0]        weight;

    assign accept = push && !full;

    // Differences and magnitudes of the bond vector and temperature
    assign dx = {bond.nbr_x[31], bond.nbr_x} - {bond.self_x[31], bond.self_x};
    assign dy = {bond.nbr_y[31], bond.nbr_y} - {bond.self_y[31], bond.self_y};
    assign dz = {bond.nbr_z[31], bond.nbr_z} - {bond.self_z[31], bond.self_z};
    assign dt = {bond.nbr_temp_change[31], bond.nbr_temp_change}
              - {bond.self_temp_change[31], bond.self_temp_change};
    assign mx = dx[32] ? 33'(-dx) : 33'(dx);
    assign my = dy[32] ? 33'(-dy) : 33'(dy);
    assign mz = dz[32] ? 33'(-dz) : 33'(dz);
    assign mt = dt[32] ? 33'(-dt) : 33'(dt);

    // Clamp damage to one
    assign weight = (bond.bond_damage > DAMAGE_ONE) ? 17'd0 : DAMAGE_ONE - bond.bond_damage;

    // One square per cycle
    assign sq = {33'd0, mag_reg[sel_reg]} * {33'd0, mag_reg[sel_reg]};

    // Digit-by-digit square root step, two bits of the sum per cycle
    assign rem2    = {rem_reg, sum_reg[65:64]};
    assign trial   = {2'b00, root_reg, 2'b01};
    assign ge      = rem2 >= trial;
    assign rem_sub = rem2 - trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            sel_reg   <= 2'd0;
            cnt_reg   <= 6'd0;
        end
        else
        begin
            unique case (state_reg)
                F_IDLE:
                begin
                    if (accept)
                    begin
                        sel_reg   <= 2'd0;
                        state_reg <= F_SQ;
                    end
                end
                F_SQ:
                begin
                    sel_reg <= sel_reg + 2'd1;
                    if (sel_reg == 2'd2)
                    begin
                        cnt_reg   <= 6'd33;
                        state_reg <= F_ROOT;
                    end
                end
                F_ROOT:
                begin
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd1)
                    begin
                        state_reg <= F_PUSH;
                    end
                end
                F_PUSH:
                begin
                    if (job_ready)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

    // Datapath: capture the word, then square, sum and root
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mag_reg[0] <= mx;
            mag_reg[1] <= my;
            mag_reg[2] <= mz;
            adt_reg    <= mt;
            neg_reg    <= dt[32];
            weight_reg <= weight;
            volume_reg <= bond.nbr_volume;
            last_reg   <= bond.last_bond;
            sum_reg    <= '0;
            rem_reg    <= '0;
            root_reg   <= '0;
        end
        else if (state_reg == F_SQ)
        begin
            sum_reg <= sum_reg + sq;
        end
        else if (state_reg == F_ROOT)
        begin
            sum_reg  <= {sum_reg[63:0], 2'b00};
            rem_reg  <= ge ? rem_sub[34:0] : rem2[34:0];
            root_reg <= {root_reg[31:0], ge};
        end
    end

    assign full       = (state_reg != F_IDLE);
    assign job_valid  = (state_reg == F_PUSH);
    assign job.len    = root_reg;
    assign job.adt    = adt_reg;
    assign job.neg    = neg_reg;
    assign job.weight = weight_reg;
    assign job.volume = volume_reg;
    assign job.last   = last_reg;

endmodule

### rtl/core/bhfa_queue.sv
module bhfa_queue
    import bhfa_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  bond_job_t in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output bond_job_t out_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    bond_job_t        mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr, do_rd;

    assign in_ready  = (count_reg != FULL_CNT);
    assign out_valid = (count_reg != '0);
    assign do_wr     = in_valid && in_ready;
    assign do_rd     = out_valid && out_ready;
    assign out_data  = mem[rd_ptr_reg];

    // Store the word
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= in_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

### rtl/core/bhfa_back.sv
module bhfa_back
    import bhfa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        job_valid,
    output logic        job_ready,
    input  bond_job_t   job,
    input  logic [63:0] micro_scale,
    input  logic        micro_busy,
    output logic        empty,
    input  logic        pop,
    output result_t     result
);

    typedef enum logic [1:0] {B_IDLE, B_MUL, B_DIV, B_ACC} b_state_t;

    b_state_t     state_reg;
    logic [145:0] a_reg, p_reg;
    logic [32:0]  b_reg;
    logic [7:0]   cnt_reg;
    logic [1:0]   phase_reg;
    logic [32:0]  rem_reg;
    logic [63:0]  q_reg;
    logic         ovf_reg;
    logic [32:0]  len_reg, adt_reg;
    logic [31:0]  volume_reg;
    logic         neg_reg, last_reg, skip_reg;
    logic [63:0]  sum_reg;
    logic         zl_reg, sat_reg;
    result_t      out_reg;
    logic         out_valid_reg;

    logic         take;
    logic [145:0] p_next;
    logic [33:0]  rem2, rem_sub;
    logic         ge;
    logic [63:0]  q_next;
    logic         ovf_next;
    logic [63:0]  max_mag, mag, term, raw_sum, sat_sum;
    logic         clamp, add_ovf;
    logic [63:0]  new_sum;
    logic         new_zl, new_sat, out_free;

    assign job_ready = (state_reg == B_IDLE) && !micro_busy;
    assign take      = job_valid && job_ready;

    // Shift-add step for M*w*|dT|*volume
    assign p_next = {p_reg[144:0], 1'b0} + (b_reg[32] ? a_reg : 146'd0);

    // Restoring divide step by the bond length
    assign rem2     = {rem_reg, p_reg[145]};
    assign ge       = rem2 >= {1'b0, len_reg};
    assign rem_sub  = rem2 - {1'b0, len_reg};
    assign q_next   = {q_reg[62:0], ge};
    assign ovf_next = ovf_reg | q_reg[63];

    // Clamp the term and add with saturation
    assign max_mag = neg_reg ? SIGN64 : POS64;
    assign clamp   = ovf_reg || (q_reg > max_mag);
    assign mag     = clamp ? max_mag : q_reg;
    assign term    = neg_reg ? (64'd0 - mag) : mag;
    assign raw_sum = sum_reg + term;
    assign add_ovf = ((~(sum_reg ^ term)) & (sum_reg ^ raw_sum) & SIGN64) != 64'd0;
    assign sat_sum = add_ovf ? (sum_reg[63] ? SIGN64 : POS64) : raw_sum;
    assign new_sum = skip_reg ? sum_reg : sat_sum;
    assign new_zl  = zl_reg | skip_reg;
    assign new_sat = skip_reg ? sat_reg : (sat_reg | clamp | add_ovf);
    assign out_free = !out_valid_reg || pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            sum_reg       <= '0;
            zl_reg        <= 1'b0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            phase_reg     <= '0;
        end
        else
        begin
            // Drop the result once taken
            if (pop && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                B_IDLE:
                begin
                    if (take)
                    begin
                        if (job.len == 33'd0)
                        begin
                            state_reg <= B_ACC;
                        end
                        else
                        begin
                            cnt_reg   <= 8'd17;
                            phase_reg <= 2'd0;
                            state_reg <= B_MUL;
                        end
                    end
                end
                B_MUL:
                begin
                    cnt_reg <= cnt_reg - 8'd1;
                    if (cnt_reg == 8'd1)
                    begin
                        phase_reg <= phase_reg + 2'd1;
                        if (phase_reg == 2'd0)
                        begin
                            cnt_reg <= 8'd33;
                        end
                        else if (phase_reg == 2'd1)
                        begin
                            cnt_reg <= 8'd32;
                        end
                        else
                        begin
                            cnt_reg   <= 8'd114;
                            state_reg <= B_DIV;
                        end
                    end
                end
                B_DIV:
                begin
                    cnt_reg <= cnt_reg - 8'd1;
                    if (cnt_reg == 8'd1)
                    begin
                        state_reg <= B_ACC;
                    end
                end
                B_ACC:
                begin
                    if (!last_reg)
                    begin
                        sum_reg   <= new_sum;
                        zl_reg    <= new_zl;
                        sat_reg   <= new_sat;
                        state_reg <= B_IDLE;
                    end
                    else if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        sum_reg       <= '0;
                        zl_reg        <= 1'b0;
                        sat_reg       <= 1'b0;
                        state_reg     <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            len_reg    <= job.len;
            adt_reg    <= job.adt;
            volume_reg <= job.volume;
            neg_reg    <= job.neg;
            last_reg   <= job.last;
            skip_reg   <= (job.len == 33'd0);
            a_reg      <= {82'd0, micro_scale};
            p_reg      <= '0;
            b_reg      <= {job.weight, 16'd0};
        end
        else if (state_reg == B_MUL)
        begin
            p_reg <= p_next;
            b_reg <= {b_reg[31:0], 1'b0};
            if (cnt_reg == 8'd1)
            begin
                rem_reg <= '0;
                q_reg   <= '0;
                ovf_reg <= 1'b0;
                if (phase_reg != 2'd2)
                begin
                    a_reg <= p_next;
                    p_reg <= '0;
                    b_reg <= (phase_reg == 2'd0) ? adt_reg : {volume_reg, 1'b0};
                end
            end
        end
        else if (state_reg == B_DIV)
        begin
            p_reg   <= {p_reg[144:0], 1'b0};
            rem_reg <= ge ? rem_sub[32:0] : rem2[32:0];
            q_reg   <= q_next;
            ovf_reg <= ovf_next;
        end
        else if (state_reg == B_ACC && last_reg && out_free)
        begin
            out_reg.heat_flow_sum    <= new_sum;
            out_reg.zero_length_seen <= new_zl;
            out_reg.saturated        <= new_sat;
        end
    end

    assign empty  = !out_valid_reg;
    assign result = out_reg;

endmodule

### rtl/core/bhfa_checker.sv
`include "assert_macros.svh"

module bhfa_props
    import bhfa_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   push,
    input logic                   full,
    input logic                   empty,
    input logic                   pop,
    input result_t                result,
    input logic                   cfg_valid,
    input logic                   cfg_ready,
    input logic [CFG_INDEX_W-1:0] cfg_index
);

    logic cfg_known_wr;

    // Flag a write that lands on a defined register
    assign cfg_known_wr = cfg_valid && cfg_ready
                       && (cfg_index == REG_CONDUCTIVITY || cfg_index == REG_HORIZON);

    // Hold a waiting result until it is taken
    `BHFA_ASSERT(a_result_hold, (!empty && !pop) |=> (!empty && $stable(result)))

    // A write to a known register starts a recompute
    `BHFA_ASSERT(a_cfg_busy, cfg_known_wr |=> !cfg_ready)

    // An accepted bond keeps the front busy the next cycle
    `BHFA_NEVER(a_push_busy, $past(push && !full && rst_n) && !full)

endmodule

bind bond_heat_flow_accumulator bhfa_props u_bhfa_props (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index)
);

### bench/bhfa_checker.sv
module bhfa_checker
    import bhfa_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic                   full,
    input  bond_in_t               bond,
    input  logic                   empty,
    input  logic                   pop,
    input  result_t                result,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]            cfg_data,
    output int                     fail_count,
    output int                     sums_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [31:0] k_reg;
    logic [31:0] h_reg;
    logic [63:0] scale;
    logic [63:0] acc;
    logic        zero_seen;
    logic        sat_seen;
    result_t     owed_sums[$];

    assign sums_owed = owed_sums.size();

    // Scale 6k/(pi*h^3) in Q32.32, clamped to all ones
    function automatic logic [63:0] heat_scale(logic [31:0] k, logic [31:0] h);
        logic [191:0] num;
        logic [191:0] den;
        logic [191:0] q;
        num = (192'(k) * 192'(6)) << MICRO_SHIFT;
        den = 192'(PI_Q30) * 192'(h) * 192'(h) * 192'(h);
        if (den == '0)
            return '1;
        q = num / den;
        if (q > 192'(64'hFFFF_FFFF_FFFF_FFFF))
            return '1;
        return q[63:0];
    endfunction

    // Floor square root of a 66-bit sum of squares
    function automatic logic [32:0] bond_length(logic [65:0] v);
        logic [69:0] rem;
        logic [69:0] trial;
        logic [33:0] root;
        rem = '0;
        root = '0;
        for (int i = 32; i >= 0; i--)
        begin
            rem = (rem << 2) | 70'(v[2*i +: 2]);
            trial = (70'(root) << 2) | 70'd1;
            if (rem >= trial)
            begin
                rem = rem - trial;
                root = (root << 1) | 34'd1;
            end
            else
                root = root << 1;
        end
        return root[32:0];
    endfunction

    // Apply one bond to the running point and owe a sum on its last bond
    task automatic take_bond(bond_in_t b);
        longint      d;
        logic [65:0] sq_sum;
        logic [32:0] len;
        logic [16:0] w;
        logic [32:0] adt;
        logic        neg;
        logic [191:0] num;
        logic [191:0] q;
        logic [63:0] lim;
        logic [63:0] mag;
        logic [63:0] term;
        logic [63:0] s;
        result_t     r;
        d = longint'(b.nbr_x) - longint'(b.self_x);
        if (d < 0) d = -d;
        sq_sum = 66'(d) * 66'(d);
        d = longint'(b.nbr_y) - longint'(b.self_y);
        if (d < 0) d = -d;
        sq_sum = sq_sum + 66'(d) * 66'(d);
        d = longint'(b.nbr_z) - longint'(b.self_z);
        if (d < 0) d = -d;
        sq_sum = sq_sum + 66'(d) * 66'(d);
        len = bond_length(sq_sum);
        if (len == '0)
            zero_seen = 1'b1;
        else
        begin
            w = (b.bond_damage > DAMAGE_ONE) ? 17'd0 : DAMAGE_ONE - b.bond_damage;
            d = longint'(b.nbr_temp_change) - longint'(b.self_temp_change);
            neg = d < 0;
            if (neg) d = -d;
            adt = 33'(d);
            num = 192'(scale) * 192'(w) * 192'(adt[31:0]) * 192'(b.nbr_volume);
            q = num / (192'(len) << 32);
            lim = neg ? SIGN64 : POS64;
            if (q > 192'(lim))
            begin
                mag = lim;
                sat_seen = 1'b1;
            end
            else
                mag = q[63:0];
            term = neg ? -mag : mag;
            s = acc + term;
            if ((~(acc ^ term) & (acc ^ s) & SIGN64) != '0)
            begin
                s = acc[63] ? SIGN64 : POS64;
                sat_seen = 1'b1;
            end
            acc = s;
        end
        if (b.last_bond)
        begin
            r.heat_flow_sum = acc;
            r.zero_length_seen = zero_seen;
            r.saturated = sat_seen;
            owed_sums.push_back(r);
            acc = '0;
            zero_seen = 1'b0;
            sat_seen = 1'b0;
        end
    endtask

    // Watch all three channels and compare each popped word
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            k_reg = RESET_CONDUCTIVITY;
            h_reg = RESET_HORIZON;
            scale = heat_scale(RESET_CONDUCTIVITY, RESET_HORIZON);
            acc = '0;
            zero_seen = 1'b0;
            sat_seen = 1'b0;
            owed_sums.delete();
            fail_count = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_CONDUCTIVITY)
                    k_reg = cfg_data;
                else if (cfg_index == REG_HORIZON)
                    h_reg = cfg_data;
                scale = heat_scale(k_reg, h_reg);
            end
            if (push && !full)
                take_bond(bond);
            if (pop && !empty)
            begin
                if (owed_sums.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result word: sum %h zl %b sat %b",
                                 result.heat_flow_sum, result.zero_length_seen,
                                 result.saturated);
                end
                else
                begin
                    want = owed_sums.pop_front();
                    if (result.heat_flow_sum !== want.heat_flow_sum ||
                        result.zero_length_seen !== want.zero_length_seen ||
                        result.saturated !== want.saturated)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("result word differs: sum %h/%h zl %b/%b sat %b/%b",
                                     want.heat_flow_sum, result.heat_flow_sum,
                                     want.zero_length_seen, result.zero_length_seen,
                                     want.saturated, result.saturated);
                    end
                end
            end
        end
    end

endmodule

### bench/bond_heat_flow_accumulator_tb.sv
module bond_heat_flow_accumulator_tb;
    import bhfa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE = 1500;
    localparam longint LIMIT = 4000000;

    logic                   clk;
    logic                   rst_n;
    logic                   push;
    logic                   full;
    bond_in_t               bond;
    logic                   empty;
    logic                   pop;
    result_t                result;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [31:0]            cfg_data;
    int                     fail_count;
    int                     sums_owed;

    int     send_idle_pct;
    int     pop_stall_pct;
    int     hold_request;
    longint cycles;

    bond_heat_flow_accumulator uut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .bond(bond),
        .empty(empty), .pop(pop), .result(result), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    bhfa_checker chk (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .bond(bond),
        .empty(empty), .pop(pop), .result(result), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .sums_owed(sums_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Abort on a hung run
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > LIMIT)
            begin
                $display("bond_heat_flow_accumulator: mismatch");
                $finish;
            end
        end
    end

    // Drain results, with random stalls and long hold-offs on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        pop = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= pop_stall_pct);
        end
    end

    // Offer one word, idling first at random
    task automatic send_bond(bond_in_t b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        bond <= b;
        do
            @(posedge clk);
        while (full);
    endtask

    // Write one register once the block has gone quiet
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] val);
        push <= 1'b0;
        while (sums_owed != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(3))
            0: return $urandom();
            1: return $urandom_range(200000);
            2: return -$urandom_range(200000);
            default: return $urandom_range(3) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
        endcase
    endfunction

    // Random bond, biased toward short bonds and moderate values
    function automatic bond_in_t rand_bond(logic last);
        bond_in_t b;
        b.self_x = pick_word();
        b.self_y = pick_word();
        b.self_z = pick_word();
        if ($urandom_range(7) == 0)
        begin
            b.nbr_x = b.self_x;
            b.nbr_y = b.self_y;
            b.nbr_z = b.self_z;
        end
        else if ($urandom_range(2) == 0)
        begin
            b.nbr_x = pick_word();
            b.nbr_y = pick_word();
            b.nbr_z = pick_word();
        end
        else
        begin
            b.nbr_x = b.self_x + $signed($urandom_range(262144)) - 131072;
            b.nbr_y = b.self_y + $signed($urandom_range(262144)) - 131072;
            b.nbr_z = b.self_z + $signed($urandom_range(262144)) - 131072;
        end
        b.self_temp_change = pick_word();
        b.nbr_temp_change = ($urandom_range(9) == 0) ? b.self_temp_change : pick_word();
        b.nbr_volume = ($urandom_range(2) == 0) ? $urandom() : $urandom_range(131072);
        case ($urandom_range(4))
            0: b.bond_damage = 17'd0;
            1: b.bond_damage = DAMAGE_ONE;
            2: b.bond_damage = 17'($urandom_range(131071));
            default: b.bond_damage = 17'($urandom_range(65536));
        endcase
        b.last_bond = last;
        return b;
    endfunction

    function automatic bond_in_t edge_bond(logic [31:0] s, logic [31:0] n, logic [31:0] ts,
                                           logic [31:0] tn, logic [31:0] vol,
                                           logic [16:0] dmg, logic last);
        bond_in_t b;
        b.self_x = s;
        b.self_y = s;
        b.self_z = s;
        b.nbr_x = n;
        b.nbr_y = n;
        b.nbr_z = n;
        b.self_temp_change = ts;
        b.nbr_temp_change = tn;
        b.nbr_volume = vol;
        b.bond_damage = dmg;
        b.last_bond = last;
        return b;
    endfunction

    initial
    begin
        logic [31:0] k_set[11];
        logic [31:0] h_set[11];
        int          idle_set[4];
        int          stall_set[4];
        int          n;
        rst_n = 1'b0;
        push = 1'b0;
        bond = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_CONDUCTIVITY;
        cfg_data = '0;
        send_idle_pct = 0;
        pop_stall_pct = 0;
        hold_request = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, zero length, damage cases, saturation
        send_bond(edge_bond(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 17'd0, 1'b1));
        send_bond(edge_bond(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                            32'hFFFF_FFFF, 17'd0, 1'b1));
        send_bond(edge_bond(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                            32'hFFFF_FFFF, 17'd0, 1'b1));
        send_bond(edge_bond(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                            32'hFFFF_FFFF, 17'd0, 1'b0));
        send_bond(edge_bond(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                            32'hFFFF_FFFF, 17'd0, 1'b1));
        send_bond(edge_bond(32'h0, 32'h1, 32'h0, 32'h10000, 32'h10000, 17'd0, 1'b0));
        send_bond(edge_bond(32'h1234, 32'h1234, 32'h0, 32'h10000, 32'h10000, 17'd0, 1'b0));
        send_bond(edge_bond(32'h0, 32'h10000, 32'h0, 32'h10000, 32'h10000, DAMAGE_ONE, 1'b0));
        send_bond(edge_bond(32'h0, 32'h10000, 32'h0, 32'h10000, 32'h10000, 17'h1FFFF, 1'b0));
        send_bond(edge_bond(32'h0, 32'h10000, 32'h0, 32'h10000, 32'h10000, 17'd32768, 1'b1));
        send_bond(edge_bond(32'h5, 32'h5, 32'h0, 32'h0, 32'h0, 17'd0, 1'b1));
        send_bond(edge_bond(32'h0, 32'h20000, 32'h30000, 32'h10000, 32'h20000, 17'd100, 1'b1));
        write_reg(REG_HORIZON, 32'h0);
        send_bond(edge_bond(32'h0, 32'h10000, 32'h0, 32'h1, 32'h1, 17'd0, 1'b0));
        write_reg(REG_CONDUCTIVITY, 32'hFFFF_FFFF);
        send_bond(edge_bond(32'h0, 32'h10000, 32'h0, 32'h1, 32'h1, 17'd0, 1'b1));
        write_reg(REG_HORIZON, 32'h1);
        send_bond(edge_bond(32'h0, 32'h10000, 32'h1, 32'h0, 32'h1, 17'd0, 1'b1));
        write_reg(REG_HORIZON, 32'hFFFF_FFFF);
        send_bond(edge_bond(32'h0, 32'h1, 32'h8000_0000, 32'h7FFF_FFFF,
                            32'hFFFF_FFFF, 17'd0, 1'b1));
        write_reg(REG_CONDUCTIVITY, 32'h0);
        send_bond(edge_bond(32'h0, 32'h10000, 32'h0, 32'h10000, 32'h10000, 17'd0, 1'b1));

        // Random phases across register settings and idle patterns
        k_set = '{32'h10000, 32'h0, 32'hFFFF_FFFF, 32'h8000, 32'h3_0000, 32'h10000,
                  32'h1, 32'h2_8000, 32'hFFFF_FFFF, 32'h10000, 32'h4000};
        h_set = '{32'h10000, 32'h10000, 32'h1, 32'h0, 32'h3_0000, 32'hFFFF_FFFF,
                  32'h8000, 32'h2_0000, 32'h10_0000, 32'h1_8000, 32'h40};
        idle_set = '{0, 55, 0, 16};
        stall_set = '{0, 0, 55, 16};
        for (int p = 0; p < 11; p++)
        begin
            write_reg(REG_CONDUCTIVITY, (p == 10) ? $urandom() : k_set[p]);
            write_reg(REG_HORIZON, (p == 10) ? ($urandom() | 32'h1) : h_set[p]);
            send_idle_pct = idle_set[p % 4];
            pop_stall_pct = stall_set[p % 4];
            if (p == 4 || p == 8)
                hold_request = 3000;
            n = 0;
            while (n < 148)
            begin
                send_bond(rand_bond($urandom_range(2) == 0));
                n++;
            end
        end
        push <= 1'b0;

        // Let everything drain, then decide
        while (sums_owed != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0)
            $display("bond_heat_flow_accumulator: match");
        else
            $display("bond_heat_flow_accumulator: mismatch");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/bhfa_pkg.sv
rtl/core/bhfa_micro.sv
rtl/core/bhfa_front.sv
rtl/core/bhfa_queue.sv
rtl/core/bhfa_back.sv
rtl/core/bond_heat_flow_accumulator.sv
rtl/core/bhfa_checker.sv
bench/bhfa_checker.sv
bench/bond_heat_flow_accumulator_tb.sv
